/* src/crcfc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crcfc_pkg
// Shared types, constants and the byte-wide CRC-32 update for the frame
// checker.
// ----------------------------------------------------------------------------
package crcfc_pkg;

    localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam logic [7:0]  START_BYTE = 8'h7E;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HDR0    = 3'd1,
        PH_HDR1    = 3'd2,
        PH_HDR2    = 3'd3,
        PH_HDR3    = 3'd4,
        PH_LENGTH  = 3'd5,
        PH_PAYLOAD = 3'd6
    } phase_t;

    typedef struct packed {
        logic        crc_ok;
        logic [7:0]  payload_length;
        logic [31:0] computed_crc;
        logic [31:0] received_crc;
    } result_t;

    // MSB-first CRC-32, eight bits per call
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        logic        fb;
        crc = crc_in;
        for (int k = 7; k >= 0; k--)
        begin
            fb  = crc[31] ^ data[k];
            crc = {crc[30:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

/* src/crc32_frame_checker.sv */
`default_nettype none
// Result path: the last payload word (or the length word for an empty payload)
// is held in the input register, then its result loads the result register.
// Throughput: one word per cycle; the CRC update is an unrolled 8-bit step
// between the input register and the result register. The input stalls only
// while the result register holds a word the sink has not taken.
// Reset: rst_n async-clears valid flags and parser; the parser starts idle.
// ----------------------------------------------------------------------------
// crc32_frame_checker
// Byte-serial frame receiver with MSB-first CRC-32 check.
// ----------------------------------------------------------------------------
module crc32_frame_checker
    import crcfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  frame_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             crc_ok,
    output logic [7:0]       payload_length,
    output logic [31:0]      computed_crc,
    output logic [31:0]      received_crc
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       advance;
    logic       emit;
    logic       room;
    result_t    result;
    result_t    result_out;

    // every word, result or not, waits for space in the result register
    assign advance = byte_valid && room;

    crcfc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .frame_byte (frame_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    crcfc_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .byte_data (byte_data),
        .emit      (emit),
        .result    (result)
    );

    crcfc_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit),
        .result     (result),
        .room       (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result_out)
    );

    assign crc_ok         = result_out.crc_ok;
    assign payload_length = result_out.payload_length;
    assign computed_crc   = result_out.computed_crc;
    assign received_crc   = result_out.received_crc;

endmodule
`default_nettype wire

/* src/crcfc_in_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crcfc_in_stage
// Input register: holds one received word until the frame logic consumes it.
// ----------------------------------------------------------------------------
module crcfc_in_stage
    import crcfc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] frame_byte,
    input  wire logic       advance,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= frame_byte;
        end
    end

endmodule
`default_nettype wire

/* src/crcfc_frame.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crcfc_frame
// Frame parser: start byte, CRC header, length, payload CRC update and
// result generation.
// ----------------------------------------------------------------------------
module crcfc_frame
    import crcfc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic [7:0] byte_data,
    output logic            emit,
    output result_t         result
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [31:0] hdr_crc_reg;
    logic [31:0] hdr_crc_next;
    logic [7:0]  length_reg;
    logic [7:0]  length_next;
    logic [7:0]  left_reg;
    logic [7:0]  left_next;
    logic [31:0] run_crc_reg;
    logic [31:0] run_crc_next;

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_crc_next = hdr_crc_reg;
        length_next  = length_reg;
        left_next    = left_reg;
        run_crc_next = run_crc_reg;
        emit         = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (byte_data == START_BYTE)
                begin
                    hdr_crc_next = '0;
                    run_crc_next = '0;
                    phase_next   = PH_HDR0;
                end
            end
            PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3:
            begin
                hdr_crc_next = {hdr_crc_reg[23:0], byte_data};
                phase_next   = phase_t'(phase_reg + 3'd1);
            end
            PH_LENGTH:
            begin
                length_next  = byte_data;
                left_next    = byte_data;
                run_crc_next = '0;
                if (byte_data == 8'd0)
                begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                run_crc_next = crc_byte(run_crc_reg, byte_data);
                left_next    = left_reg - 8'd1;
                if (left_next == 8'd0)
                begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        emit = emit && advance;
    end

    assign result.crc_ok         = (run_crc_next == hdr_crc_next);
    assign result.payload_length = length_next;
    assign result.computed_crc   = run_crc_next;
    assign result.received_crc   = hdr_crc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            hdr_crc_reg <= '0;
            length_reg  <= '0;
            left_reg    <= '0;
            run_crc_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            hdr_crc_reg <= hdr_crc_next;
            length_reg  <= length_next;
            left_reg    <= left_next;
            run_crc_reg <= run_crc_next;
        end
    end

endmodule
`default_nettype wire

/* src/crcfc_out_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crcfc_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module crcfc_out_stage
    import crcfc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  result_t      result,
    output logic         room,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      result_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign room       = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (room)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && room)
        begin
            result_reg <= result;
        end
    end

endmodule
`default_nettype wire

/* src/crcfc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crcfc_checker
// Port-level assertions for crc32_frame_checker.
// ----------------------------------------------------------------------------
module crcfc_checker
    import crcfc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [7:0]  frame_byte,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        crc_ok,
    input wire logic [7:0]  payload_length,
    input wire logic [31:0] computed_crc,
    input wire logic [31:0] received_crc
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(frame_byte))
        else $error("input word changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(crc_ok)
            && $stable(payload_length) && $stable(computed_crc)
            && $stable(received_crc))
        else $error("result word changed while stalled");

    a_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> crc_ok == (computed_crc == received_crc))
        else $error("crc_ok disagrees with CRC fields");

    a_empty_crc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_length == 8'd0 |-> computed_crc == 32'd0)
        else $error("empty payload with nonzero CRC");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

endmodule

bind crc32_frame_checker crcfc_checker u_crcfc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .frame_byte     (frame_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .crc_ok         (crc_ok),
    .payload_length (payload_length),
    .computed_crc   (computed_crc),
    .received_crc   (received_crc)
);
`default_nettype wire

/* tb/sv/tb_crc32_frame_checker.sv */
// ----------------------------------------------------------------------------
// tb_crc32_frame_checker
// Self-checking bench for the byte-serial CRC-32 frame checker. A short
// table of directed words covers idle noise, empty payloads with zero and
// all-ones header CRCs, and start bytes used as plain data. Random frames
// follow: mostly well-formed with a right, random or one-bit-off header CRC,
// mixed with noise and cut-off frames. An internal frame parser predicts the
// results of untyped words, and a monitor compares results in order.
// ----------------------------------------------------------------------------
module tb_crc32_frame_checker
    import crcfc_pkg::*;
();

    localparam int WORK_TARGET = 1200;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 21;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        result_t    want;
    } dir_row_t;

    localparam int N_DIR = 22;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{START_BYTE, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{1'b1, 8'd0, 32'h0000_0000, 32'h0000_0000}},
        '{START_BYTE, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b1, '{1'b0, 8'd0, 32'h0000_0000, 32'hFFFF_FFFF}},
        '{START_BYTE, 1'b0, '0},
        '{START_BYTE, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{START_BYTE, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{START_BYTE, 1'b0, '0},
        '{8'hFF, 1'b0, '0}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  frame_byte;
    logic        out_valid;
    logic        out_ready;
    logic        crc_ok;
    logic [7:0]  payload_length;
    logic [31:0] computed_crc;
    logic [31:0] received_crc;

    // frame parser state
    phase_t      ph;
    logic [31:0] hdr_crc;
    logic [7:0]  len_seen;
    logic [7:0]  left;
    logic [31:0] run_crc;

    result_t     pending_results[$];
    int          err_cnt;
    int          work_cnt;
    int          words_sent;
    int          n_results;
    int          n_pass;
    int          hold_reqs;
    logic        calm;

    crc32_frame_checker u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .frame_byte     (frame_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .crc_ok         (crc_ok),
        .payload_length (payload_length),
        .computed_crc   (computed_crc),
        .received_crc   (received_crc)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // byte folded in at the top, then eight shifts
    function automatic logic [31:0] crc32_fold(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c ^ {d, 24'h0};
        repeat (8)
        begin
            r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic bit parse_word(input logic [7:0] b, output result_t res);
        bit done;
        done = 1'b0;
        res  = '0;
        case (ph)
            PH_IDLE:
            begin
                if (b == START_BYTE)
                begin
                    hdr_crc = '0;
                    run_crc = '0;
                    ph      = PH_HDR0;
                end
            end
            PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3:
            begin
                hdr_crc = {hdr_crc[23:0], b};
                ph      = phase_t'(ph + 3'd1);
            end
            PH_LENGTH:
            begin
                len_seen = b;
                left     = b;
                run_crc  = '0;
                if (b == 8'd0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                run_crc = crc32_fold(run_crc, b);
                left    = left - 8'd1;
                done    = (left == 8'd0);
            end
            default:
            begin
                ph = PH_IDLE;
            end
        endcase
        if (done)
        begin
            res = '{run_crc == hdr_crc, len_seen, run_crc, hdr_crc};
            ph  = PH_IDLE;
        end
        return done;
    endfunction

    function automatic int pick_length();
        int p;
        p = $urandom_range(99);
        if (p < 1)
        begin
            return 255;
        end
        else if (p < 5)
        begin
            return $urandom_range(17, 254);
        end
        else if (p < 15)
        begin
            return 0;
        end
        return $urandom_range(1, 16);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic typed, input result_t want);
        result_t res;
        bit      got;
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        frame_byte <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (ph != PH_IDLE || b == START_BYTE)
        begin
            work_cnt++;
        end
        got = parse_word(b, res);
        if (typed)
        begin
            pending_results.push_back(want);
        end
        else if (got)
        begin
            pending_results.push_back(res);
        end
    endtask

    // crc_mode: 0 right CRC, 1 random, 2 one bit off; n_words may cut it short
    task automatic send_frame(input int len, input int crc_mode, input int n_words);
        logic [7:0]  words[$];
        logic [7:0]  pay[$];
        logic [31:0] c;
        logic [31:0] hdr;
        c = '0;
        for (int i = 0; i < len; i++)
        begin
            pay.push_back(8'($urandom));
            c = crc32_fold(c, pay[i]);
        end
        case (crc_mode)
            0:       hdr = c;
            1:       hdr = $urandom;
            default: hdr = c ^ (32'h1 << $urandom_range(0, 31));
        endcase
        words.push_back(START_BYTE);
        words.push_back(hdr[31:24]);
        words.push_back(hdr[23:16]);
        words.push_back(hdr[15:8]);
        words.push_back(hdr[7:0]);
        words.push_back(8'(len));
        words = {words, pay};
        for (int i = 0; i < n_words && i < words.size(); i++)
        begin
            send_word(words[i], 1'b0, '0);
        end
    endtask

    initial
    begin : tx_side
        int stage;
        int p;
        int len;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        frame_byte = '0;
        calm       = 1'b0;
        hold_reqs  = 0;
        err_cnt    = 0;
        work_cnt   = 0;
        words_sent = 0;
        n_results  = 0;
        n_pass     = 0;
        ph         = PH_IDLE;
        hdr_crc    = '0;
        len_seen   = '0;
        left       = '0;
        run_crc    = '0;
        stage      = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
        begin
            send_word(DIR_ROWS[i].data, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end
        send_frame(255, 0, 261);
        send_frame(1, 2, 7);

        while (work_cnt < WORK_TARGET)
        begin
            if (stage == 0 && work_cnt >= 300)
            begin
                // receiver stalls while empty frames pile up
                hold_reqs++;
                repeat (12) send_frame(0, $urandom_range(0, 1), 6);
                stage = 1;
            end
            else if (stage == 1 && work_cnt >= 600)
            begin
                calm  = 1'b1;
                stage = 2;
            end
            else if (stage == 2 && work_cnt >= 800)
            begin
                calm = 1'b0;
                @(negedge clk);
                in_valid <= 1'b0;
                wait (pending_results.size() == 0);
                stage = 3;
            end
            p = $urandom_range(99);
            if (p < 80)
            begin
                len = pick_length();
                send_frame(len, $urandom_range(0, 2), len + 6);
            end
            else if (p < 90)
            begin
                repeat ($urandom_range(1, 4)) send_word(8'($urandom), 1'b0, '0);
            end
            else
            begin
                len = pick_length();
                send_frame(len, $urandom_range(0, 2), $urandom_range(1, len + 5));
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(posedge clk);
        $display("Sent %0d words (%0d parsed), checked %0d frame results, %0d with CRC match.",
                 words_sent, work_cnt, n_results, n_pass);
        $display("Included empty and 255-word payloads, noise, cut frames and a %0d-cycle stall.",
                 HOLD_CYCLES);
        if (err_cnt == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin : rx_side
        int stretch;
        int seen;
        stretch   = 0;
        seen      = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_reqs != seen)
            begin
                seen    = hold_reqs;
                stretch = HOLD_CYCLES;
            end
            if (stretch > 0)
            begin
                out_ready <= 1'b0;
                stretch--;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: payload_length %0d, computed_crc %h",
                       payload_length, computed_crc);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                n_results++;
                if (crc_ok)
                begin
                    n_pass++;
                end
                if (crc_ok !== want.crc_ok)
                begin
                    $error("crc_ok: expected %0d, got %0d", want.crc_ok, crc_ok);
                    err_cnt++;
                end
                if (payload_length !== want.payload_length)
                begin
                    $error("payload_length: expected %0d, got %0d",
                           want.payload_length, payload_length);
                    err_cnt++;
                end
                if (computed_crc !== want.computed_crc)
                begin
                    $error("computed_crc: expected %h, got %h", want.computed_crc, computed_crc);
                    err_cnt++;
                end
                if (received_crc !== want.received_crc)
                begin
                    $error("received_crc: expected %h, got %h", want.received_crc, received_crc);
                    err_cnt++;
                end
            end
        end
    end

endmodule
